// ----- hw/rtl/tusw_pkg.sv -----
package tusw_pkg;

  // result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
  localparam logic [2:0] KIND_END      = 3'd2;
  localparam logic [2:0] KIND_NO_USTAR = 3'd3;
  localparam logic [2:0] KIND_BAD_TYPE = 3'd4;

  localparam logic [8:0] BLK_LAST   = 9'd511;
  localparam logic [8:0] OFS_SIZE   = 9'd124;
  localparam logic [8:0] OFS_SIZE_E = 9'd135;
  localparam logic [8:0] OFS_TYPE   = 9'd156;
  localparam logic [8:0] OFS_MAGIC  = 9'd257;
  localparam logic [8:0] OFS_MAGIC_E = 9'd261;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] file_size;
    logic        last_of_file;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t word;
  } fifo_head_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75; // u
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h72; // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/tusw_front.sv -----
module tusw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [7:0]           byte_i,
  output logic                 push_o,
  output tusw_pkg::result_t    word_o
);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_PADDING = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        pen_q;
  logic [8:0]  ofs_q, ofs_d;
  logic [63:0] acc_q, acc_d;
  logic        skip_q, skip_d, stop_q, stop_d, bin_q, bin_d;
  logic        magic_q, magic_d, type_q, type_d, zero_q, zero_d;
  logic [63:0] rem_q, rem_d;
  logic [8:0]  pad_q, pad_d;
  logic [8:0]  mofs;
  logic        last;

  assign mofs = ofs_q - tusw_pkg::OFS_MAGIC;
  assign last = (rem_q[63:1] == 63'd0);

  always_comb begin
    phase_d = phase_q;
    ofs_d   = ofs_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    stop_d  = stop_q;
    bin_d   = bin_q;
    magic_d = magic_q;
    type_d  = type_q;
    zero_d  = zero_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    push_o  = 1'b0;
    word_o  = '0;
    if (accept_i) begin
      case (phase_q)
        PH_HEADER: begin
          if (ofs_q == 9'd0 && byte_i == 8'd0) zero_d = 1'b1;
          if (ofs_q >= tusw_pkg::OFS_SIZE && ofs_q <= tusw_pkg::OFS_SIZE_E) begin
            if (ofs_q == tusw_pkg::OFS_SIZE && byte_i[7]) begin
              // base-256 size: first byte dropped
              bin_d  = 1'b1;
              skip_d = 1'b0;
              stop_d = 1'b0;
              acc_d  = '0;
            end else if (bin_q) begin
              acc_d = {acc_q[55:0], byte_i};
            end else if (!stop_q) begin
              if (!(skip_q && byte_i == tusw_pkg::CH_SPACE)) begin
                skip_d = 1'b0;
                if (byte_i >= tusw_pkg::CH_ZERO && byte_i <= tusw_pkg::CH_SEVEN) begin
                  acc_d = {acc_q[60:0], byte_i[2:0]};
                end else begin
                  stop_d = 1'b1;
                end
              end
            end
          end
          if (ofs_q == tusw_pkg::OFS_TYPE && byte_i != 8'd0 && byte_i != tusw_pkg::CH_ZERO)
            type_d = 1'b0;
          if (ofs_q >= tusw_pkg::OFS_MAGIC && ofs_q <= tusw_pkg::OFS_MAGIC_E
              && byte_i != tusw_pkg::magic_char(mofs[2:0]))
            magic_d = 1'b0;
          if (ofs_q != tusw_pkg::BLK_LAST) begin
            ofs_d = ofs_q + 9'd1;
          end else begin
            push_o = 1'b1;
            // no field lives at the last offset, so the stored flags are final
            if (zero_q) begin
              word_o.kind = tusw_pkg::KIND_END;
              phase_d = PH_HALTED;
            end else if (!magic_q) begin
              word_o.kind = tusw_pkg::KIND_NO_USTAR;
              phase_d = PH_HALTED;
            end else if (!type_q) begin
              word_o.kind = tusw_pkg::KIND_BAD_TYPE;
              phase_d = PH_HALTED;
            end else begin
              word_o.kind      = tusw_pkg::KIND_HEADER;
              word_o.file_size = acc_q;
              rem_d = acc_q;
              pad_d = 9'd0 - acc_q[8:0];
              phase_d = (acc_q == 64'd0) ? PH_HEADER : PH_PAYLOAD;
            end
            ofs_d   = '0;
            acc_d   = '0;
            skip_d  = 1'b1;
            stop_d  = 1'b0;
            bin_d   = 1'b0;
            magic_d = 1'b1;
            type_d  = 1'b1;
            zero_d  = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          if (pen_q) begin
            push_o = 1'b1;
            word_o.kind         = tusw_pkg::KIND_PAYLOAD;
            word_o.payload_byte = byte_i;
            word_o.last_of_file = last;
          end
          rem_d = last ? 64'd0 : rem_q - 64'd1;
          if (last) phase_d = (pad_q != 9'd0) ? PH_PADDING : PH_HEADER;
        end
        PH_PADDING: begin
          if (pad_q <= 9'd1) begin
            pad_d   = '0;
            phase_d = PH_HEADER;
          end else begin
            pad_d = pad_q - 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pen_q   <= 1'b0;
      ofs_q   <= '0;
      acc_q   <= '0;
      skip_q  <= 1'b1;
      stop_q  <= 1'b0;
      bin_q   <= 1'b0;
      magic_q <= 1'b1;
      type_q  <= 1'b1;
      zero_q  <= 1'b0;
      rem_q   <= '0;
      pad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) pen_q <= cfg_wdata_i;
      ofs_q   <= ofs_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      stop_q  <= stop_d;
      bin_q   <= bin_d;
      magic_q <= magic_d;
      type_q  <= type_d;
      zero_q  <= zero_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
    end
  end

endmodule

// ----- hw/rtl/tusw_fifo.sv -----
module tusw_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tusw_pkg::result_t     word_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output tusw_pkg::fifo_head_t  head_o
);

  tusw_pkg::result_t mem_q [tusw_pkg::FIFO_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o       = (cnt_q == 2'(tusw_pkg::FIFO_DEPTH));
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.word  = mem_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/tusw_back.sv -----
module tusw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tusw_pkg::fifo_head_t  head_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output tusw_pkg::result_t     word_o
);

  logic              valid_q;
  tusw_pkg::result_t word_q;

  assign pop_o   = head_i.valid && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || ready_i) begin
      valid_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) word_q <= head_i.word;
  end

endmodule

// ----- hw/rtl/tar_ustar_stream_walker.sv -----
// ustar archive walker, one archive byte per input word.
// Slave stream s_axis_*: one raw archive byte per word in tdata.
// Master stream m_axis_*: zero or one result word per input byte.
//   tuser = kind (0 file header, 1 payload byte, 2 end block, 3 not ustar,
//   4 unsupported type); tdata = payload byte, then 64-bit file size;
//   tlast = final payload byte of a file.
// cfg_we_i/cfg_wdata_i write payload_enable (1 = extract payload bytes,
//   0 = list headers only); write only while the stream is idle.
// Throughput: one byte per cycle while the queue is not full; the parser
//   front end keeps up with every byte since each needs only counter updates
//   and one field compare. A result reaches m_axis through the parser push
//   into a 2-word queue, then the output register.
// A stalled receiver fills the output register and the queue; s_axis_tready
//   drops only when the queue is full, so no word is lost.
// Reset clears the parser to the start of a header block, payload_enable to
//   0 and empties the queue. After an end block or an error the walker
//   swallows all input until the next reset.
module tar_ustar_stream_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] payload_byte, [71:8] file_size
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last_of_file
);

  logic                 accept;
  logic                 push;
  logic                 full;
  logic                 pop;
  tusw_pkg::result_t    fe_word;
  tusw_pkg::result_t    out_word;
  tusw_pkg::fifo_head_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  tusw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .push_o      (push),
    .word_o      (fe_word)
  );

  tusw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (fe_word),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  tusw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .word_o  (out_word)
  );

  assign m_axis_tdata = {out_word.file_size, out_word.payload_byte};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last_of_file;

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length guard: about 52k archive bytes at most, each worst case held up
  // by a sender gap and a receiver stall, taken several times.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned N_RANDOM = 16;
  localparam logic [0:4][7:0] USTAR = "ustar";

  // Walker phases of the local copy of the parser.
  typedef enum logic [1:0] {ST_HEADER, ST_BODY, ST_PAD, ST_HALT} walk_phase_e;

  // One archive member: header block, body bytes, then padding to 512.
  typedef struct packed {
    bit               pe;         // payload_enable while this member is sent
    logic [7:0]       name0;      // first name byte
    logic [0:11][7:0] size_fld;   // header bytes 124..135
    logic [7:0]       type_b;     // header byte 156
    bit               bad_magic;  // corrupt one magic character
    int               body;       // bytes sent after the header block
    int               flip_at;    // body index where payload_enable toggles, -1 none
    bit               typed;      // header word below is the expectation
    logic [2:0]       exp_kind;
    logic [63:0]      exp_size;
  } member_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_ready = 1'b1;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tar_ustar_stream_walker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Local archive walker: tracks the block byte by byte and yields the word
  // each accepted byte should produce.
  // ---------------------------------------------------------------------------
  bit          pe_now;
  walk_phase_e phase_q;
  logic [8:0]  hofs;
  logic [63:0] size_acc;
  bit          sz_skip, sz_stop, sz_bin;
  bit          magic_ok, type_ok, name_zero;
  logic [63:0] body_left;
  logic [8:0]  pad_left;

  function automatic void clear_header();
    hofs = '0;
    size_acc = '0;
    sz_skip = 1'b1;
    sz_stop = 1'b0;
    sz_bin = 1'b0;
    magic_ok = 1'b1;
    type_ok = 1'b1;
    name_zero = 1'b0;
  endfunction

  function automatic bit walk_byte(input logic [7:0] b, output tusw_pkg::result_t w);
    bit last;
    w = '0;
    walk_byte = 1'b0;
    case (phase_q)
      ST_HEADER: begin
        if (hofs == 9'd0 && b == 8'h00) name_zero = 1'b1;
        if (hofs >= tusw_pkg::OFS_SIZE && hofs <= tusw_pkg::OFS_SIZE_E) begin
          if (hofs == tusw_pkg::OFS_SIZE && b[7]) begin
            // base-256 size: the marker byte itself is dropped
            sz_bin = 1'b1;
            sz_skip = 1'b0;
            sz_stop = 1'b0;
            size_acc = '0;
          end else if (sz_bin) begin
            size_acc = {size_acc[55:0], b};
          end else if (!sz_stop) begin
            if (!(sz_skip && b == tusw_pkg::CH_SPACE)) begin
              sz_skip = 1'b0;
              if (b >= tusw_pkg::CH_ZERO && b <= tusw_pkg::CH_SEVEN)
                size_acc = {size_acc[60:0], b[2:0]};
              else sz_stop = 1'b1;
            end
          end
        end
        if (hofs == tusw_pkg::OFS_TYPE && b != 8'h00 && b != tusw_pkg::CH_ZERO)
          type_ok = 1'b0;
        if (hofs >= tusw_pkg::OFS_MAGIC && hofs <= tusw_pkg::OFS_MAGIC_E
            && b != USTAR[hofs - tusw_pkg::OFS_MAGIC])
          magic_ok = 1'b0;
        if (hofs != tusw_pkg::BLK_LAST) begin
          hofs = hofs + 9'd1;
        end else begin
          // block end: checks in priority order
          walk_byte = 1'b1;
          if (name_zero) begin
            w.kind = tusw_pkg::KIND_END;
            phase_q = ST_HALT;
          end else if (!magic_ok) begin
            w.kind = tusw_pkg::KIND_NO_USTAR;
            phase_q = ST_HALT;
          end else if (!type_ok) begin
            w.kind = tusw_pkg::KIND_BAD_TYPE;
            phase_q = ST_HALT;
          end else begin
            w.kind = tusw_pkg::KIND_HEADER;
            w.file_size = size_acc;
            body_left = size_acc;
            pad_left = 9'd0 - size_acc[8:0];
            phase_q = (size_acc == 64'd0) ? ST_HEADER : ST_BODY;
          end
          clear_header();
        end
      end
      ST_BODY: begin
        last = (body_left <= 64'd1);
        if (pe_now) begin
          walk_byte = 1'b1;
          w.kind = tusw_pkg::KIND_PAYLOAD;
          w.payload_byte = b;
          w.last_of_file = last;
        end
        body_left = last ? 64'd0 : body_left - 64'd1;
        if (last) phase_q = (pad_left != 9'd0) ? ST_PAD : ST_HEADER;
      end
      ST_PAD: begin
        if (pad_left <= 9'd1) begin
          pad_left = '0;
          phase_q = ST_HEADER;
        end else begin
          pad_left = pad_left - 9'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Expected words, oldest first, and the output checker.
  // ---------------------------------------------------------------------------
  tusw_pkg::result_t want_q[$];
  int unsigned n_bad = 0;
  int unsigned cyc = 0;
  bit          idle_en = 1'b0;
  int          stall_left = 0;

  task automatic report_bad(input string what, input tusw_pkg::result_t exp_w,
                            input tusw_pkg::result_t got_w);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t: %s: kind %0d/%0d byte %h/%h size %h/%h last %0d/%0d (exp/got)",
               $realtime, what, exp_w.kind, got_w.kind, exp_w.payload_byte,
               got_w.payload_byte, exp_w.file_size, got_w.file_size,
               exp_w.last_of_file, got_w.last_of_file);
  endtask

  always @(posedge clk_i) begin
    tusw_pkg::result_t got_w;
    tusw_pkg::result_t exp_w;
    if (rst_ni && m_tvalid && m_ready) begin
      got_w.kind = m_tuser;
      got_w.payload_byte = m_tdata[7:0];
      got_w.file_size = m_tdata[71:8];
      got_w.last_of_file = m_tlast;
      if (want_q.size() == 0) begin
        report_bad("unexpected word", '0, got_w);
      end else begin
        exp_w = want_q.pop_front();
        if (got_w.kind !== exp_w.kind || got_w.payload_byte !== exp_w.payload_byte ||
            got_w.file_size !== exp_w.file_size ||
            got_w.last_of_file !== exp_w.last_of_file)
          report_bad("word differs", exp_w, got_w);
      end
    end
    // receiver stalls in bursts of random length while idle_en is set
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    m_ready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one archive byte, wait for it to be taken, then record what it causes.
  // A typed header word, where given, replaces the computed one.
  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input tusw_pkg::result_t typed_w);
    tusw_pkg::result_t w;
    bit                hit;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_tdata <= b;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    hit = walk_byte(b, w);
    if (use_typed) begin
      w = typed_w;
      hit = 1'b1;
    end
    if (hit) want_q.push_back(w);
  endtask

  // Drain everything, let the last silent bytes clear the pipe, then write
  // payload_enable.
  task automatic set_enable(input bit v);
    s_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pe_now = v;
  endtask

  task automatic send_member(input member_t e);
    logic [7:0]        hdr [512];
    tusw_pkg::result_t typed_w;
    int                m;
    if (e.pe != pe_now) set_enable(e.pe);
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = e.name0;
    for (int k = 0; k < 12; k++) hdr[124 + k] = e.size_fld[k];
    hdr[156] = e.type_b;
    for (int k = 0; k < 5; k++) hdr[257 + k] = USTAR[k];
    if (e.bad_magic) begin
      m = $urandom_range(0, 4);
      hdr[257 + m] = USTAR[m] ^ 8'($urandom_range(1, 255));
    end
    typed_w = '0;
    typed_w.kind = e.exp_kind;
    typed_w.file_size = e.exp_size;
    for (int i = 0; i < 512; i++)
      send_byte(hdr[i], e.typed && i == tusw_pkg::BLK_LAST, typed_w);
    for (int j = 0; j < e.body; j++) begin
      // register change in the middle of a file
      if (j == e.flip_at) set_enable(!pe_now);
      send_byte(8'($urandom), 1'b0, typed_w);
    end
    for (int j = 0; j < (512 - e.body % 512) % 512; j++)
      send_byte(8'($urandom), 1'b0, typed_w);
  endtask

  // Random well-formed member: mostly small bodies, now and then past one block.
  // Size field in octal (11 or 12 digits, or space-led) or base-256.
  function automatic member_t rand_member();
    member_t     e;
    int unsigned sz;
    int          r, ns, w, nd;
    logic [7:0]  t;
    e = '0;
    r = $urandom_range(0, 7);
    if (r == 0) sz = 0;
    else if (r == 1) sz = $urandom_range(513, 1600);
    else sz = $urandom_range(1, 300);
    e.pe = ($urandom_range(0, 3) != 0);
    e.name0 = 8'($urandom_range(1, 255));
    e.type_b = $urandom_range(0, 1) ? tusw_pkg::CH_ZERO : 8'h00;
    e.body = sz;
    e.flip_at = -1;
    if (sz >= 2 && $urandom_range(0, 5) == 0) e.flip_at = $urandom_range(1, sz - 1);
    case ($urandom_range(0, 2))
      0: t = 8'h00;
      1: t = tusw_pkg::CH_SPACE;
      default: begin
        t = 8'($urandom);
        if (t >= tusw_pkg::CH_ZERO && t <= tusw_pkg::CH_SEVEN) t = t ^ 8'h40;
      end
    endcase
    nd = 1;
    while ((sz >> (3 * nd)) != 0) nd++;
    case ($urandom_range(0, 3))
      0: begin ns = 0; w = 11; end
      1: begin ns = 0; w = 12; end
      2: begin ns = $urandom_range(0, 11 - nd); w = nd; end
      default: begin ns = -1; w = 0; end
    endcase
    if (ns < 0) begin
      // base-256; bytes 125..127 get shifted out of the 64-bit result
      e.size_fld = {8'h80 | 8'($urandom), 24'($urandom), 48'h0, 16'(sz)};
    end else begin
      for (int p = 0; p < 12; p++) begin
        if (p < ns) e.size_fld[p] = tusw_pkg::CH_SPACE;
        else if (p < ns + w)
          e.size_fld[p] = tusw_pkg::CH_ZERO + 8'((sz >> (3 * (ns + w - 1 - p))) & 7);
        else if (p == ns + w) e.size_fld[p] = t;
        else e.size_fld[p] = 8'($urandom);
      end
    end
    return e;
  endfunction

  initial begin
    member_t plan [11];
    member_t tail;
    logic [7:0] t;

    // pe, name0, size field, type, bad magic, body, flip, typed, kind, size
    plan = '{
      '{1'b1, "a",   "00000000005 ", tusw_pkg::CH_ZERO, 1'b0,   5, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd5},
      // leading spaces skipped, space ends the digits
      '{1'b1, 8'hFF, "      17    ", 8'h00,   1'b0,  15, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd15},
      // empty file goes straight to the next header
      '{1'b1, 8'h01, "00000000000 ", tusw_pkg::CH_ZERO, 1'b0,   0, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd0},
      // non-octal digit stops the parse, list mode
      '{1'b0, "b",   "   128      ", tusw_pkg::CH_ZERO, 1'b0,  10, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd10},
      // twelve digits, no terminator; one full block, no padding
      '{1'b1, "c",   "000000001000", tusw_pkg::CH_ZERO, 1'b0, 512, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd512},
      '{1'b1, "d",   {8'h80, 24'hABCDEF, 48'h0, 16'h012C}, 8'h00, 1'b0, 300, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd300},
      // tab is not skipped
      '{1'b1, "e",   {8'h09, "17", 72'h0}, tusw_pkg::CH_ZERO, 1'b0, 0, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd0},
      '{1'b1, "f",   {8'hFF, 24'hFFFFFF, 48'h0, 16'h0007}, tusw_pkg::CH_ZERO, 1'b0, 7, -1,
        1'b1, tusw_pkg::KIND_HEADER, 64'd7},
      '{1'b1, "g",   "            ", 8'h00,   1'b0,   0, -1, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd0},
      // extract switched off mid-file: no last flag
      '{1'b1, "h",   "00000000050 ", tusw_pkg::CH_ZERO, 1'b0,  40, 20, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd40},
      // list switched to extract mid-file
      '{1'b0, "i",   "00000000036 ", tusw_pkg::CH_ZERO, 1'b0,  30, 10, 1'b1,
        tusw_pkg::KIND_HEADER, 64'd30}
    };

    pe_now = 1'b0;
    phase_q = ST_HEADER;
    body_left = '0;
    pad_left = '0;
    clear_header();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_enable(1'b1);

    foreach (plan[k]) begin
      idle_en = ($urandom_range(0, 3) != 0);
      send_member(plan[k]);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      // last members run with both sides at full rate
      idle_en = (k < N_RANDOM - 3) && ($urandom_range(0, 3) != 0);
      send_member(rand_member());
    end

    // The archive ends one way per run: each of these leaves the walker stuck.
    idle_en = 1'b0;
    tail = rand_member();
    tail.typed = 1'b1;
    tail.exp_size = '0;
    tail.flip_at = -1;
    tail.body = 30;
    case ($urandom_range(0, 4))
      0: begin
        // end block wins over bad magic and bad type
        tail.name0 = 8'h00;
        tail.bad_magic = $urandom_range(0, 1);
        tail.type_b = 8'($urandom);
        tail.exp_kind = tusw_pkg::KIND_END;
      end
      1: begin
        tail.bad_magic = 1'b1;
        tail.type_b = 8'($urandom);
        tail.exp_kind = tusw_pkg::KIND_NO_USTAR;
      end
      2: begin
        t = 8'($urandom_range(1, 255));
        if (t == tusw_pkg::CH_ZERO) t = 8'h31;
        tail.type_b = t;
        tail.exp_kind = tusw_pkg::KIND_BAD_TYPE;
      end
      3: begin
        tail.pe = 1'b1;
        tail.size_fld = '1;
        tail.body = 20;
        tail.exp_kind = tusw_pkg::KIND_HEADER;
        tail.exp_size = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      default: begin
        tail.pe = 1'b1;
        tail.size_fld = "777777777777";
        tail.body = 20;
        tail.exp_kind = tusw_pkg::KIND_HEADER;
        tail.exp_size = 64'h0000_000F_FFFF_FFFF;
      end
    endcase
    send_member(tail);

    s_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_bad == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tusw_pkg.sv
hw/rtl/tusw_front.sv
hw/rtl/tusw_fifo.sv
hw/rtl/tusw_back.sv
hw/rtl/tar_ustar_stream_walker.sv
test/tb.sv
